FILE: src/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg: shared definitions for the keyed slot table
// Field widths, operation and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package kst_pkg;

    localparam int MODE_W          = 2;
    localparam int KEY_W           = 32;
    localparam int INFO_MAX_W      = 64;
    localparam int ST_W            = 2;

    localparam int DEF_TABLE_SLOTS = 16;
    localparam int DEF_INFO_BYTES  = 8;

    localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ERASE   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_COMPACT = 2'd3;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic            load;
        logic            rd_step;
        logic            ins_write;
        logic            ins_step;
        logic            erase_clr;
        logic            hit_cap;
        logic            move;
        logic            wr_step;
        logic            res_we;
        logic [ST_W-1:0] res_status;
        logic            out_load;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] in_mode;
        logic [MODE_W-1:0] mode;
        logic              free;
        logic              idx_last;
        logic              s1_vld;
        logic              s1_hit;
        logic              s1_move;
        logic              out_free;
    } t_sts;

endpackage

FILE: src/kst_ctrl.sv
// ----------------------------------------------------------------------------
// kst_ctrl: operation sequencer for the keyed slot table
// Steps the slot scan for each operation, decides when it ends and hands the
// finished result to the output register.
// ----------------------------------------------------------------------------
module kst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  kst_pkg::t_sts i_sts,
    output kst_pkg::t_cmd o_cmd,
    output logic          o_ready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic          r_pipe;
    logic          n_pipe;
    logic          r_fin;
    logic          n_fin;
    kst_pkg::t_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        n_pipe  = r_pipe;
        n_fin   = r_fin;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    w_cmd.load = 1'b1;
                    n_pipe     = 1'b0;
                    n_fin      = 1'b0;
                    if (i_sts.in_mode == kst_pkg::MODE_INSERT) begin
                        n_state = S_INS;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_INS: begin
                if (i_sts.free) begin
                    w_cmd.ins_write = 1'b1;
                    n_state         = S_DONE;
                end else if (i_sts.idx_last) begin
                    w_cmd.res_we     = 1'b1;
                    w_cmd.res_status = kst_pkg::ST_FULL;
                    n_state          = S_DONE;
                end else begin
                    w_cmd.ins_step = 1'b1;
                end
            end
            S_SCAN: begin
                if (r_pipe && i_sts.s1_hit && (i_sts.mode != kst_pkg::MODE_COMPACT)) begin
                    if (i_sts.mode == kst_pkg::MODE_LOOKUP) begin
                        w_cmd.hit_cap = 1'b1;
                    end else begin
                        w_cmd.erase_clr = 1'b1;
                    end
                    n_pipe  = 1'b0;
                    n_state = S_DONE;
                end else begin
                    if (r_pipe && i_sts.s1_vld && (i_sts.mode == kst_pkg::MODE_COMPACT)) begin
                        w_cmd.move    = i_sts.s1_move;
                        w_cmd.wr_step = 1'b1;
                    end
                    if (r_fin) begin
                        if (i_sts.mode == kst_pkg::MODE_LOOKUP) begin
                            w_cmd.res_we     = 1'b1;
                            w_cmd.res_status = kst_pkg::ST_NOT_FOUND;
                        end
                        n_pipe  = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        w_cmd.rd_step = 1'b1;
                        n_pipe        = 1'b1;
                        n_fin         = i_sts.idx_last;
                    end
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pipe  <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pipe  <= n_pipe;
            r_fin   <= n_fin;
        end
    end

    assign o_cmd   = w_cmd;
    assign o_ready = (r_state == S_IDLE);

endmodule

FILE: src/kst_data.sv
// ----------------------------------------------------------------------------
// kst_data: slot storage and scan datapath for the keyed slot table
// Holds the valid marks in flops, keys and payloads in memories, the scan
// counters, the one-slot read stage, the pending result and the output beat.
// ----------------------------------------------------------------------------
module kst_data #(
    parameter int TABLE_SLOTS = kst_pkg::DEF_TABLE_SLOTS,
    parameter int INFO_BYTES  = kst_pkg::DEF_INFO_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [kst_pkg::MODE_W-1:0]       i_mode,
    input  logic signed [kst_pkg::KEY_W-1:0] i_key,
    input  logic [kst_pkg::INFO_MAX_W-1:0]   i_info,
    input  kst_pkg::t_cmd                    i_cmd,
    input  logic                             i_m_ready,
    output kst_pkg::t_sts                    o_sts,
    output logic                             o_m_valid,
    output logic [kst_pkg::ST_W-1:0]         o_status,
    output logic [kst_pkg::INFO_MAX_W-1:0]   o_found
);

    localparam int IDX_W  = $clog2(TABLE_SLOTS);
    localparam int INFO_W = 8 * INFO_BYTES;

    logic [kst_pkg::KEY_W-1:0]      r_key_mem [TABLE_SLOTS];
    logic [INFO_W-1:0]              r_info_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0]         r_valid;
    logic [TABLE_SLOTS-1:0]         n_valid;

    logic [kst_pkg::MODE_W-1:0]     r_mode;
    logic [kst_pkg::KEY_W-1:0]      r_key;
    logic [INFO_W-1:0]              r_info;
    logic [IDX_W-1:0]               r_idx;
    logic [IDX_W-1:0]               r_wr_idx;

    logic [kst_pkg::KEY_W-1:0]      r_s1_key;
    logic [INFO_W-1:0]              r_s1_info;
    logic                           r_s1_vld;
    logic [IDX_W-1:0]               r_s1_addr;

    logic [kst_pkg::ST_W-1:0]       r_res_status;
    logic [kst_pkg::INFO_MAX_W-1:0] r_res_info;
    logic                           r_m_valid;
    logic [kst_pkg::ST_W-1:0]       r_status;
    logic [kst_pkg::INFO_MAX_W-1:0] r_found;

    logic                           w_we;
    logic [IDX_W-1:0]               w_waddr;
    logic [kst_pkg::KEY_W-1:0]      w_wkey;
    logic [INFO_W-1:0]              w_winfo;

    always_comb begin
        w_we    = i_cmd.ins_write | i_cmd.move;
        w_waddr = i_cmd.move ? r_wr_idx : r_idx;
        w_wkey  = i_cmd.move ? r_s1_key : r_key;
        w_winfo = i_cmd.move ? r_s1_info : r_info;
    end

    always_comb begin
        n_valid = r_valid;
        if (i_cmd.ins_write) begin
            n_valid[r_idx] = 1'b1;
        end
        if (i_cmd.erase_clr) begin
            n_valid[r_s1_addr] = 1'b0;
        end
        if (i_cmd.move) begin
            n_valid[r_s1_addr] = 1'b0;
            n_valid[r_wr_idx]  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_key_mem[w_waddr]  <= w_wkey;
            r_info_mem[w_waddr] <= w_winfo;
        end
        if (i_cmd.rd_step) begin
            r_s1_key  <= r_key_mem[r_idx];
            r_s1_info <= r_info_mem[r_idx];
            r_s1_vld  <= r_valid[r_idx];
            r_s1_addr <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_cmd.out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode       <= i_mode;
            r_key        <= i_key;
            r_info       <= i_info[INFO_W-1:0];
            r_idx        <= '0;
            r_wr_idx     <= '0;
            r_res_status <= kst_pkg::ST_OK;
            r_res_info   <= '0;
        end else begin
            if (i_cmd.rd_step || i_cmd.ins_step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.wr_step) begin
                r_wr_idx <= r_wr_idx + 1'b1;
            end
            if (i_cmd.res_we) begin
                r_res_status <= i_cmd.res_status;
            end
            if (i_cmd.hit_cap) begin
                r_res_info <= kst_pkg::INFO_MAX_W'(r_s1_info);
            end
        end
        if (i_cmd.out_load) begin
            r_status <= r_res_status;
            r_found  <= r_res_info;
        end
    end

    always_comb begin
        o_sts.in_mode  = i_mode;
        o_sts.mode     = r_mode;
        o_sts.free     = ~r_valid[r_idx];
        o_sts.idx_last = (r_idx == IDX_W'(TABLE_SLOTS - 1));
        o_sts.s1_vld   = r_s1_vld;
        o_sts.s1_hit   = r_s1_vld && (r_s1_key == r_key);
        o_sts.s1_move  = (r_wr_idx != r_s1_addr);
        o_sts.out_free = ~r_m_valid | i_m_ready;
    end

    assign o_m_valid = r_m_valid;
    assign o_status  = r_status;
    assign o_found   = r_found;

`ifndef NO_ASSERTIONS
    a_ins_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_write |-> !r_valid[r_idx])
        else $error("insert writes an occupied slot");

    a_move_down : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.move |-> (r_wr_idx < r_s1_addr) && r_s1_vld)
        else $error("compaction move does not go down from a valid slot");

    a_hit_match : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.hit_cap || i_cmd.erase_clr) |-> r_s1_vld && (r_s1_key == r_key))
        else $error("hit taken on a slot that does not match");

    a_out_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_m_valid || i_m_ready))
        else $error("result overwrites a beat not yet taken");

    a_erase_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.erase_clr |=> !r_valid[$past(r_s1_addr)])
        else $error("erase left the slot valid");
`endif

endmodule

FILE: src/keyed_slot_table_top.sv
// ----------------------------------------------------------------------------
// keyed_slot_table_top: fixed-size key/value table with compaction
// Each input beat on the slave channel carries one operation (insert,
// lookup, erase or compact); each yields exactly one result beat on the
// master channel with a status code and, for a successful lookup, the stored
// payload. Operations are handled one at a time.
// Insert scans up to the first free slot, or every slot when the table is
// full. Lookup and erase stop at the first matching slot, or scan every slot
// when none matches. Compact always scans every slot. The slot scan reads
// one slot per cycle through the single read port of the key and payload
// memories and moves at most one entry per cycle during compaction.
// A new beat is accepted as soon as the previous operation has placed its
// result in the output register, even while that result still waits. If the
// receiver stalls, the next operation runs to completion and then holds until
// the output register is free. Reset clears every valid mark and the output valid.
// ----------------------------------------------------------------------------
module keyed_slot_table_top #(
    parameter int TABLE_SLOTS = kst_pkg::DEF_TABLE_SLOTS,
    parameter int INFO_BYTES  = kst_pkg::DEF_INFO_BYTES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // key [31:0], entry_info [95:32]
    input  logic [1:0]   s_axis_tuser,   // mode [1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // found_info [63:0]
    output logic [1:0]   m_axis_tuser    // status [1:0]
);

    kst_pkg::t_cmd w_cmd;
    kst_pkg::t_sts w_sts;
    logic          w_ready;
    logic          w_start;

    assign w_start       = s_axis_tvalid & w_ready;
    assign s_axis_tready = w_ready;

    kst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_ready (w_ready)
    );

    kst_data #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .INFO_BYTES  (INFO_BYTES)
    ) u_data (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mode    (s_axis_tuser),
        .i_key     (s_axis_tdata[31:0]),
        .i_info    (s_axis_tdata[95:32]),
        .i_cmd     (w_cmd),
        .i_m_ready (m_axis_tready),
        .o_sts     (w_sts),
        .o_m_valid (m_axis_tvalid),
        .o_status  (m_axis_tuser),
        .o_found   (m_axis_tdata)
    );

endmodule

FILE: dv/keyed_slot_table_checker.sv
// ----------------------------------------------------------------------------
// keyed_slot_table_checker: result predictor and scoreboard
// Watches both stream channels of the keyed slot table. Every accepted
// operation beat runs through a private copy of the slot table, and the
// status and payload it should produce are queued. Every accepted result beat
// is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module keyed_slot_table_checker #(
    parameter int TABLE_SLOTS = kst_pkg::DEF_TABLE_SLOTS,
    parameter int INFO_BYTES  = kst_pkg::DEF_INFO_BYTES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_op_tvalid,
    input  logic         i_op_tready,
    input  logic [95:0]  i_op_tdata,     // key [31:0], entry_info [95:32]
    input  logic [1:0]   i_op_tuser,     // mode [1:0]
    input  logic         i_res_tvalid,
    input  logic         i_res_tready,
    input  logic [63:0]  i_res_tdata,    // found_info [63:0]
    input  logic [1:0]   i_res_tuser,    // status [1:0]
    output int           o_mismatches,
    output int           o_results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [kst_pkg::ST_W-1:0]       status;
        logic [kst_pkg::INFO_MAX_W-1:0] info;
    } t_table_reply;

    localparam logic [kst_pkg::INFO_MAX_W-1:0] PAYLOAD_MASK =
        {kst_pkg::INFO_MAX_W{1'b1}} >> (64 - 8 * INFO_BYTES);

    bit                             slot_used [TABLE_SLOTS];
    logic [kst_pkg::KEY_W-1:0]      slot_key  [TABLE_SLOTS];
    logic [kst_pkg::INFO_MAX_W-1:0] slot_info [TABLE_SLOTS];

    t_table_reply replies_due [$];
    int           mismatch_count = 0;
    int           due_count      = 0;

    assign o_mismatches  = mismatch_count;
    assign o_results_due = due_count;

    function automatic int lowest_match(input logic [kst_pkg::KEY_W-1:0] key);
        int hit;
        hit = -1;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            if (slot_used[i] && slot_key[i] == key) begin
                hit = i;
            end
        end
        return hit;
    endfunction

    function automatic t_table_reply apply_table_op(
        input logic [kst_pkg::MODE_W-1:0]     mode,
        input logic [kst_pkg::KEY_W-1:0]      key,
        input logic [kst_pkg::INFO_MAX_W-1:0] info);
        t_table_reply reply;
        int           hit;
        int           wr;
        bit           placed;
        reply.status = kst_pkg::ST_OK;
        reply.info   = '0;
        placed       = 1'b0;
        wr           = 0;
        case (mode)
            kst_pkg::MODE_INSERT: begin
                for (int i = 0; i < TABLE_SLOTS; i++) begin
                    if (!placed && !slot_used[i]) begin
                        slot_used[i] = 1'b1;
                        slot_key[i]  = key;
                        slot_info[i] = info & PAYLOAD_MASK;
                        placed       = 1'b1;
                    end
                end
                if (!placed) begin
                    reply.status = kst_pkg::ST_FULL;
                end
            end
            kst_pkg::MODE_LOOKUP: begin
                hit = lowest_match(key);
                if (hit >= 0) begin
                    reply.info = slot_info[hit];
                end else begin
                    reply.status = kst_pkg::ST_NOT_FOUND;
                end
            end
            kst_pkg::MODE_ERASE: begin
                hit = lowest_match(key);
                if (hit >= 0) begin
                    slot_used[hit] = 1'b0;
                end
            end
            default: begin
                for (int rd = 0; rd < TABLE_SLOTS; rd++) begin
                    if (slot_used[rd]) begin
                        if (wr != rd) begin
                            slot_key[wr]  = slot_key[rd];
                            slot_info[wr] = slot_info[rd];
                            slot_used[wr] = 1'b1;
                            slot_used[rd] = 1'b0;
                        end
                        wr++;
                    end
                end
            end
        endcase
        return reply;
    endfunction

    always @(posedge i_clk) begin
        t_table_reply want;
        int           bad;
        bad = 0;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                slot_used[i] = 1'b0;
            end
            replies_due.delete();
        end else begin
            if (i_res_tvalid && i_res_tready) begin
                if (replies_due.size() == 0) begin
                    $error("result beat with no operation outstanding: status %0d, found_info %h",
                           i_res_tuser, i_res_tdata);
                    bad++;
                end else begin
                    want = replies_due.pop_front();
                    if (i_res_tuser !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_res_tuser);
                        bad++;
                    end
                    if (i_res_tdata !== want.info) begin
                        $error("found_info mismatch: expected %h, actual %h",
                               want.info, i_res_tdata);
                        bad++;
                    end
                end
            end
            if (i_op_tvalid && i_op_tready) begin
                replies_due.push_back(apply_table_op(i_op_tuser, i_op_tdata[31:0],
                                                     i_op_tdata[95:32]));
            end
        end
        mismatch_count <= mismatch_count + bad;
        due_count      <= replies_due.size();
    end

endmodule

FILE: dv/keyed_slot_table_top_tb.sv
// ----------------------------------------------------------------------------
// keyed_slot_table_top_tb: testbench for the keyed slot table
// A directed sequence fills the table to capacity and walks through lookup
// misses, duplicate keys, erases with and without a match and compaction.
// Random phases follow with keys drawn mostly from a small pool so that
// lookups and erases hit, under varying sender gaps and receiver stalls.
// A separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module keyed_slot_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS   = kst_pkg::DEF_TABLE_SLOTS;
    localparam int INFO_BYTES    = kst_pkg::DEF_INFO_BYTES;
    localparam int STALL_LIMIT   = 4000;
    localparam int PHASE_OPS     = 125;
    localparam int DRAIN_CYCLES  = TABLE_SLOTS + 8;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata;    // key [31:0], entry_info [95:32]
    logic [1:0]   s_axis_tuser;    // mode [1:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;    // found_info [63:0]
    logic [1:0]   m_axis_tuser;    // status [1:0]

    int mismatches;
    int results_due;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int insert_pct     = 40;
    int quiet_cycles   = 0;

    logic [kst_pkg::KEY_W-1:0] key_pool [8];
    logic [kst_pkg::KEY_W-1:0] fill_keys [TABLE_SLOTS] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h7FFF_FFFF, 32'h0000_0001, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
        32'h1234_5678, 32'hFEDC_BA98, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
        32'h0000_FFFF, 32'hFFFF_0000, 32'h3333_CCCC, 32'hCCCC_3333
    };

    always #5 i_clk = ~i_clk;

    keyed_slot_table_top #(
        .TABLE_SLOTS(TABLE_SLOTS),
        .INFO_BYTES (INFO_BYTES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    keyed_slot_table_checker #(
        .TABLE_SLOTS(TABLE_SLOTS),
        .INFO_BYTES (INFO_BYTES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_tvalid  (s_axis_tvalid),
        .i_op_tready  (s_axis_tready),
        .i_op_tdata   (s_axis_tdata),
        .i_op_tuser   (s_axis_tuser),
        .i_res_tvalid (m_axis_tvalid),
        .i_res_tready (m_axis_tready),
        .i_res_tdata  (m_axis_tdata),
        .i_res_tuser  (m_axis_tuser),
        .o_mismatches (mismatches),
        .o_results_due(results_due)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("keyed_slot_table_top verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_op(input logic [kst_pkg::MODE_W-1:0] mode,
                           input logic [kst_pkg::KEY_W-1:0] key,
                           input logic [kst_pkg::INFO_MAX_W-1:0] info);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {info, key};
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_random_op;
        logic [kst_pkg::MODE_W-1:0]     mode;
        logic [kst_pkg::KEY_W-1:0]      key;
        logic [kst_pkg::INFO_MAX_W-1:0] info;
        int                             pick;
        pick = $urandom_range(99);
        if (pick < insert_pct) begin
            mode = kst_pkg::MODE_INSERT;
        end else if (pick < insert_pct + 30) begin
            mode = kst_pkg::MODE_LOOKUP;
        end else if (pick < 90) begin
            mode = kst_pkg::MODE_ERASE;
        end else begin
            mode = kst_pkg::MODE_COMPACT;
        end
        if ($urandom_range(3) != 0) begin
            key = key_pool[$urandom_range(7)];
        end else begin
            key = $urandom;
        end
        info = {$urandom, $urandom};
        send_op(mode, key, info);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= kst_pkg::MODE_INSERT;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table: miss, erase without a match, compact with nothing to move.
        send_op(kst_pkg::MODE_LOOKUP, 32'h8000_0000, {kst_pkg::INFO_MAX_W{1'b1}});
        send_op(kst_pkg::MODE_ERASE, 32'h7FFF_FFFF, '0);
        send_op(kst_pkg::MODE_COMPACT, 32'hFFFF_FFFF, {kst_pkg::INFO_MAX_W{1'b1}});
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            send_op(kst_pkg::MODE_INSERT, fill_keys[i],
                    (i == 0) ? '0 : (i == 1) ? {kst_pkg::INFO_MAX_W{1'b1}}
                                             : {$urandom, $urandom});
        end
        send_op(kst_pkg::MODE_INSERT, 32'h0BAD_0BAD, {kst_pkg::INFO_MAX_W{1'b1}});
        send_op(kst_pkg::MODE_LOOKUP, 32'h7FFF_FFFF, '0);
        send_op(kst_pkg::MODE_ERASE, 32'h7FFF_FFFF, '0);
        send_op(kst_pkg::MODE_LOOKUP, 32'h7FFF_FFFF, '0);
        send_op(kst_pkg::MODE_ERASE, 32'h8000_0000, '0);
        send_op(kst_pkg::MODE_COMPACT, '0, '0);
        send_op(kst_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, '0);
        send_op(kst_pkg::MODE_INSERT, 32'hDEAD_BEEF, 64'h0123_4567_89AB_CDEF);
        wait_for_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                    insert_pct     = 45;
                end
                1: begin
                    send_gap_pct   = 53;
                    recv_stall_pct = 0;
                    insert_pct     = 30;
                end
                2: begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 53;
                    insert_pct     = 45;
                end
                default: begin
                    send_gap_pct   = 11;
                    recv_stall_pct = 11;
                    insert_pct     = 30;
                end
            endcase
            key_pool[0] = 32'h8000_0000;
            key_pool[1] = 32'h7FFF_FFFF;
            key_pool[2] = 32'h0000_0000;
            key_pool[3] = 32'hFFFF_FFFF;
            for (int i = 4; i < 8; i++) begin
                key_pool[i] = $urandom;
            end
            for (int n = 0; n < PHASE_OPS; n++) begin
                send_random_op();
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && results_due == 0) begin
            $display("keyed_slot_table_top verification clean");
        end else begin
            $display("keyed_slot_table_top verification failed");
        end
        $finish;
    end

endmodule
